// ===== rtl/sblru_pkg.sv =====
// shared types, constants and helpers for the size-budget lru list
`timescale 1ns / 1ps
package sblru_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned CAP_W = 22;
  localparam int unsigned KB_SHIFT = 10;
  localparam logic [CAP_W-1:0] CAP_RESET = 22'd1024;

  localparam logic [1:0] CMD_ADMIT  = 2'd0;
  localparam logic [1:0] CMD_TOUCH  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [31:0] size;
    logic [31:0] idx;
  } entry_t;

  // byte total minus v, clamped at zero
  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] v);
    sat_sub = (v > a) ? 32'd0 : a - v;
  endfunction

endpackage

// ===== rtl/sblru_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module sblru_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/size_budget_lru_list.sv =====
// size-aware lru list of cached file indices with a byte budget
//
//  channel | dir | ports                                   | contents (low bit up)
//  --------+-----+-----------------------------------------+-----------------------------------
//  in      | in  | in_tvalid in_tready in_tdata in_tuser   | tuser: cmd; tdata: index, size
//  out     | out | out_tvalid out_tready out_tdata         | tuser: is_eviction; tlast: last
//          |     | out_tuser out_tlast                     | tdata: index, acc, pres, bytes
//  cfg     | in  | cfg_wr_en cfg_wr_data                   | cache capacity in kilobytes
//
// one command at a time through a small sequencer around a single entry ram
// (one read and one write port); search, compaction and eviction each step an entry
// through a pair of states (read/compare, read/write, check/emit); a rejected
// admit or unused cmd goes straight to the status result
// synchronous active-low reset clears the counters and head; the entry ram has
// no clearing pass, only entries below the count are ever read
// in_tready is high only in idle; a stalled out channel holds the sequencer
// in any state that produces a result, the last status may wait while a new
// command is accepted
`timescale 1ns / 1ps
module size_budget_lru_list
  import sblru_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input transfer
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // [31:0] file_index, [63:32] file_size
  input  logic [1:0]       in_tuser,   // [1:0] cmd
  // result transfer
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,  // [31:0] evicted_index, [32] accepted,
                                       // [33] was_present, [65:34] used_bytes, rest zero
  output logic             out_tuser,  // [0] is_eviction
  output logic             out_tlast,  // last result of the command
  // capacity register
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = AW + 2;
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_ENTRIES);
  localparam logic [AW-1:0] HEAD_LAST = AW'(MAX_ENTRIES - 1);
  localparam logic [SW-1:0] DEPTH_SW = SW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,   // read list position pos_r
    S_SRCH_CMP,  // compare its index
    S_CMP_RD,    // compaction: read the entry after pos_r
    S_CMP_WR,    // compaction: write it one place down
    S_EV_CHK,    // decide between eviction and append
    S_EV_EMIT,   // report the oldest entry and drop it
    S_APPEND,    // store the new file as most recent
    S_STATUS     // final status result
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     cmd_r, cmd_nxt;
  logic [31:0]    idx_r, idx_nxt;
  logic [31:0]    size_r, size_nxt;
  logic [31:0]    sz_r, sz_nxt;       // size of the entry found by the search
  logic [CW-1:0]  pos_r, pos_nxt;
  logic           acc_r, acc_nxt;
  logic           pres_r, pres_nxt;
  logic [AW-1:0]  head_r, head_nxt;   // ram slot of the oldest entry
  logic [CW-1:0]  count_r, count_nxt;
  logic [31:0]    bytes_r, bytes_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  logic [71:0]    out_tdata_r, out_tdata_nxt;
  logic           out_tuser_r, out_tuser_nxt;
  logic           out_tlast_r, out_tlast_nxt;

  logic           ram_wr_en;
  logic [AW-1:0]  ram_wr_addr;
  entry_t         ram_wr_data;
  logic           ram_rd_en;
  logic [AW-1:0]  ram_rd_addr;
  entry_t         ram_rd_data;

  logic [31:0]    budget;
  logic           over_budget;
  logic           out_free;
  logic [CW-1:0]  pos_inc;

  // list position to ram slot, the list is a ring starting at head_r
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] p);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(p);
    if (sum >= DEPTH_SW) begin
      sum = sum - DEPTH_SW;
    end
    slot_of = sum[AW-1:0];
  endfunction

  sblru_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign budget      = {cap_r, {KB_SHIFT{1'b0}}};
  assign over_budget = ({1'b0, bytes_r} + {1'b0, size_r}) > {1'b0, budget};
  assign out_free    = !out_tvalid_r || out_tready;
  assign pos_inc     = pos_r + CW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    size_nxt       = size_r;
    sz_nxt         = sz_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    pres_nxt       = pres_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    bytes_nxt      = bytes_r;
    cap_nxt        = cfg_wr_en ? cfg_wr_data : cap_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = slot_of(head_r, pos_r);
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = slot_of(head_r, pos_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = in_tuser;
          idx_nxt  = in_tdata[31:0];
          size_nxt = in_tdata[63:32];
          pos_nxt  = '0;
          acc_nxt  = 1'b0;
          pres_nxt = 1'b0;
          unique case (in_tuser) inside
            CMD_ADMIT: begin
              state_nxt = (in_tdata[63:32] > budget) ? S_STATUS : S_SRCH_RD;
            end
            CMD_TOUCH, CMD_REMOVE: state_nxt = S_SRCH_RD;
            default: state_nxt = S_STATUS;
          endcase
        end
      end

      S_SRCH_RD: begin
        if (pos_r < count_r) begin
          ram_rd_en = 1'b1;
          state_nxt = S_SRCH_CMP;
        end else begin
          state_nxt = (cmd_r == CMD_ADMIT) ? S_EV_CHK : S_STATUS;
        end
      end

      S_SRCH_CMP: begin
        if (ram_rd_data.idx == idx_r) begin
          sz_nxt    = ram_rd_data.size;
          pres_nxt  = (cmd_r != CMD_ADMIT);
          if (cmd_r != CMD_TOUCH) begin
            bytes_nxt = sat_sub(bytes_r, ram_rd_data.size);
          end
          state_nxt = S_CMP_RD;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = S_SRCH_RD;
        end
      end

      S_CMP_RD: begin
        if (pos_inc < count_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = slot_of(head_r, pos_inc);
          state_nxt   = S_CMP_WR;
        end else if (cmd_r == CMD_TOUCH) begin
          // found entry goes back in as most recent, count unchanged
          ram_wr_en        = 1'b1;
          ram_wr_data.idx  = idx_r;
          ram_wr_data.size = sz_r;
          state_nxt        = S_STATUS;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = (cmd_r == CMD_ADMIT) ? S_EV_CHK : S_STATUS;
        end
      end

      S_CMP_WR: begin
        ram_wr_en = 1'b1;
        pos_nxt   = pos_inc;
        state_nxt = S_CMP_RD;
      end

      S_EV_CHK: begin
        if ((count_r != '0 && over_budget) || count_r == COUNT_FULL) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = head_r;
          state_nxt   = S_EV_EMIT;
        end else begin
          state_nxt = S_APPEND;
        end
      end

      S_EV_EMIT: begin
        if (out_free) begin
          bytes_nxt      = sat_sub(bytes_r, ram_rd_data.size);
          head_nxt       = (head_r == HEAD_LAST) ? '0 : head_r + AW'(1);
          count_nxt      = count_r - CW'(1);
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = 1'b1;
          out_tlast_nxt  = 1'b0;
          out_tdata_nxt  = {6'd0, bytes_nxt, 1'b0, 1'b0, ram_rd_data.idx};
          state_nxt      = S_EV_CHK;
        end
      end

      S_APPEND: begin
        ram_wr_en        = 1'b1;
        ram_wr_addr      = slot_of(head_r, count_r);
        ram_wr_data.idx  = idx_r;
        ram_wr_data.size = size_r;
        count_nxt        = count_r + CW'(1);
        bytes_nxt        = bytes_r + size_r;
        acc_nxt          = 1'b1;
        state_nxt        = S_STATUS;
      end

      S_STATUS: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = 1'b0;
          out_tlast_nxt  = 1'b1;
          out_tdata_nxt  = {6'd0, bytes_r, pres_r, acc_r, 32'd0};
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      bytes_r      <= '0;
      cap_r        <= CAP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      cap_r        <= cap_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    size_r      <= size_nxt;
    sz_r        <= sz_nxt;
    pos_r       <= pos_nxt;
    acc_r       <= acc_nxt;
    pres_r      <= pres_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("entry count above list depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= HEAD_LAST)
    else $error("head slot out of range");

  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r) |-> (!out_tlast_r && cmd_r == CMD_ADMIT))
    else $error("eviction result marked last or outside admit");

  a_evict_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_EMIT && out_free) |=> (bytes_r <= $past(bytes_r)))
    else $error("byte total grew on eviction");

  a_evict_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_EMIT) |-> (count_r != '0))
    else $error("eviction from an empty list");
`endif

endmodule
